// ----- rtl/core/vbpd_pkg.sv -----
package vbpd_pkg;

  // Number of ordinary palette entries. The two fixed palette-screen colors
  // sit right above them.
  localparam int unsigned PaletteColors = 16;

  localparam int unsigned ModeW  = 4;
  localparam int unsigned AddrW  = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ColorW = 5;
  localparam int unsigned PairW  = 3;

  localparam logic [PairW-1:0] LastPair = PairW'(7);

  // Palette-screen color selection: color byte masked and compared.
  localparam logic [ByteW-1:0] PalSelMask  = 8'h78;
  localparam logic [ByteW-1:0] PalSelMatch = 8'h30;

  localparam logic [ColorW-1:0] PalColorA = ColorW'(PaletteColors);
  localparam logic [ColorW-1:0] PalColorB = ColorW'(PaletteColors + 1);

  typedef enum logic [ModeW-1:0] {
    MODE_COL40    = 4'd0,
    MODE_BITMAP4  = 4'd1,
    MODE_PAGE1    = 4'd2,
    MODE_PAGE2    = 4'd3,
    MODE_STACK2   = 4'd4,
    MODE_COL80    = 4'd5,
    MODE_STACK4   = 4'd6,
    MODE_BITMAP4B = 4'd7,
    MODE_BITMAP16 = 4'd8,
    MODE_PALETTE  = 4'd9
  } mode_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] cell_addr;
    logic [ByteW-1:0] form_byte;
    logic [ByteW-1:0] color_byte;
  } cell_t;

  typedef struct packed {
    logic [ColorW-1:0] color_left;
    logic [ColorW-1:0] color_right;
    logic [PairW-1:0]  pair_index;
    logic              last_pair;
  } pair_t;

endpackage

// ----- rtl/core/video_byte_pixel_decoder.sv -----
// Pipeline: the first pixel pair of a cell passes the input register and then the result
// register before it appears on the result ports; the other seven follow one per cycle.
// Flow: a new cell word is taken while the eighth pair is built, so words follow back to
// back, paced by the single result port that carries one pair per cycle.
// Reset: rst_ni (asynchronous, active low) clears the control state and the split
// register; result_valid_o is low and busy_o is low after reset. No output stall.
module video_byte_pixel_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Cell word command channel.
  input  logic                       start_i,
  output logic                       busy_o,
  input  vbpd_pkg::cell_t            cell_i,
  // Split address register write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [vbpd_pkg::AddrW-1:0] cfg_data_i,
  // Pixel pair results, one cycle each.
  output logic                       result_valid_o,
  output vbpd_pkg::pair_t            result_o
);

  // The input register holds the current cell while its eight pairs are
  // produced. pair_q counts which pair is built in this cycle.
  vbpd_pkg::cell_t                   cell_q;
  logic                              cell_vld_q, cell_vld_d;
  logic [vbpd_pkg::PairW-1:0]        pair_q, pair_d;
  logic [vbpd_pkg::AddrW-1:0]        split_q;
  logic                              res_vld_q;
  vbpd_pkg::pair_t                   res_q, res_d;
  logic                              accept;

  // The block can take a new word when no cell is held, or when the held cell
  // is on its last pair: the new cell is loaded at the same edge at which the
  // last pair moves into the result register.
  assign busy_o      = cell_vld_q && (pair_q != vbpd_pkg::LastPair);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign cell_vld_d = accept || (cell_vld_q && (pair_q != vbpd_pkg::LastPair));

  always_comb begin
    pair_d = pair_q;
    if (accept) begin
      pair_d = '0;
    end else if (cell_vld_q) begin
      pair_d = pair_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q <= 1'b0;
      pair_q     <= '0;
      res_vld_q  <= 1'b0;
      split_q    <= '0;
    end else begin
      cell_vld_q <= cell_vld_d;
      pair_q     <= pair_d;
      res_vld_q  <= cell_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        split_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q <= cell_i;
    end
    if (cell_vld_q) begin
      res_q <= res_d;
    end
  end

  // Pair decode. The bit selections below are small picks indexed by the pair
  // counter; the palette split adds an address compare against split_q.
  logic [vbpd_pkg::ByteW-1:0]  f, c;
  logic [vbpd_pkg::ByteW-1:0]  half_src;
  logic [vbpd_pkg::PairW-1:0]  bit_sel;
  logic [1:0]                  quad_sel;
  logic                        f_bit, c_bit;
  logic                        hi_bit, lo_bit;
  logic                        pal_low;
  logic [vbpd_pkg::ColorW-1:0] fg, bg;
  logic [vbpd_pkg::ColorW-1:0] left, right;

  always_comb begin
    f        = cell_q.form_byte;
    c        = cell_q.color_byte;
    // Pixels run from the most significant bit down.
    bit_sel  = ~pair_q;
    f_bit    = f[bit_sel];
    c_bit    = c[bit_sel];
    // Pairs 0..3 draw from the form byte, pairs 4..7 from the color byte, in
    // the modes that split the cell into two-bit or four-bit fields.
    half_src = pair_q[2] ? c : f;
    quad_sel = ~pair_q[1:0];
    hi_bit   = half_src[{quad_sel, 1'b1}];
    lo_bit   = half_src[{quad_sel, 1'b0}];

    // Palette screen below the split draws the fixed colors; above it, and
    // for every code without a mode of its own, the 40-column colors apply.
    pal_low = (cell_q.mode == vbpd_pkg::MODE_PALETTE) && (cell_q.cell_addr < split_q);
    if (pal_low) begin
      if ((c & vbpd_pkg::PalSelMask) == vbpd_pkg::PalSelMatch) begin
        fg = vbpd_pkg::PalColorA;
        bg = vbpd_pkg::PalColorB;
      end else begin
        fg = vbpd_pkg::PalColorB;
        bg = vbpd_pkg::PalColorA;
      end
    end else begin
      fg = {1'b0, ~c[6], c[5:3]};
      bg = {1'b0, ~c[7], c[2:0]};
    end

    left  = f_bit ? fg : bg;
    right = left;
    unique case (cell_q.mode)
      vbpd_pkg::MODE_BITMAP4: begin
        left  = {3'b000, f_bit, c_bit};
        right = left;
      end
      vbpd_pkg::MODE_PAGE1: begin
        left  = {4'b0000, f_bit};
        right = left;
      end
      vbpd_pkg::MODE_PAGE2: begin
        left  = {3'b000, c_bit, 1'b0};
        right = left;
      end
      vbpd_pkg::MODE_STACK2: begin
        if (f_bit) begin
          left = 5'd1;
        end else if (c_bit) begin
          left = 5'd2;
        end else begin
          left = 5'd0;
        end
        right = left;
      end
      vbpd_pkg::MODE_COL80: begin
        left  = {4'b0000, hi_bit};
        right = {4'b0000, lo_bit};
      end
      vbpd_pkg::MODE_STACK4: begin
        // Four stacked planes; each plane bit covers two pairs.
        if (f[{1'b1, ~pair_q[2:1]}]) begin
          left = 5'd1;
        end else if (f[{1'b0, ~pair_q[2:1]}]) begin
          left = 5'd2;
        end else if (c[{1'b1, ~pair_q[2:1]}]) begin
          left = 5'd3;
        end else if (c[{1'b0, ~pair_q[2:1]}]) begin
          left = 5'd4;
        end else begin
          left = 5'd0;
        end
        right = left;
      end
      vbpd_pkg::MODE_BITMAP4B: begin
        left  = {3'b000, hi_bit, lo_bit};
        right = left;
      end
      vbpd_pkg::MODE_BITMAP16: begin
        left  = pair_q[1] ? {1'b0, half_src[3:0]} : {1'b0, half_src[7:4]};
        right = left;
      end
      default: begin
        left  = f_bit ? fg : bg;
        right = left;
      end
    endcase

    res_d.color_left  = left;
    res_d.color_right = right;
    res_d.pair_index  = pair_q;
    res_d.last_pair   = (pair_q == vbpd_pkg::LastPair);
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ----- rtl/core/vbpd_checker.sv -----
module vbpd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       result_valid_o,
  input vbpd_pkg::pair_t            result_o
);

  // An accepted word shows its first pair once it has passed the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 (result_valid_o && (result_o.pair_index == '0)))
  else $error("first pair of an accepted word did not appear");

  // A first pair only ever follows an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.pair_index == '0)) |-> $past(start_i && !busy_o, 2))
  else $error("first pair without an accepted word");

  // Pairs of a word come back to back in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_pair) |=>
      (result_valid_o && (result_o.pair_index == $past(result_o.pair_index) + 1'b1)))
  else $error("pair sequence broken");

  // The last-pair flag marks exactly the eighth pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.last_pair == (result_o.pair_index == vbpd_pkg::LastPair)))
  else $error("last pair flag mismatch");

endmodule

bind video_byte_pixel_decoder vbpd_checker u_vbpd_checker (.*);
